// ===== design/ted_pkg.sv =====
// Shared types and constants for the text encoding detector.
package ted_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       buffer_empty;
  } in_item_t;

  typedef struct packed {
    logic [2:0] encoding;
    logic [2:0] mark_length;
  } out_item_t;

  // Final per-buffer status handed from the accumulator to the decision stage.
  typedef struct packed {
    logic [31:0] head_bytes;
    logic        high_bit_seen;
    logic        utf8_invalid;
    logic [1:0]  pending_continuations;
  } ted_snap_t;

  localparam logic [2:0] ENC_UTF8     = 3'd0;
  localparam logic [2:0] ENC_UTF16BE  = 3'd1;
  localparam logic [2:0] ENC_UTF16LE  = 3'd2;
  localparam logic [2:0] ENC_UTF32BE  = 3'd3;
  localparam logic [2:0] ENC_UTF32LE  = 3'd4;
  localparam logic [2:0] ENC_LATIN1   = 3'd5;

  localparam logic [2:0] MARK_NONE    = 3'd0;
  localparam logic [2:0] MARK_UTF16   = 3'd2;
  localparam logic [2:0] MARK_UTF8    = 3'd3;
  localparam logic [2:0] MARK_UTF32   = 3'd4;

  localparam logic [31:0] BOM_UTF32BE = 32'h0000_FEFF;
  localparam logic [31:0] BOM_UTF32LE = 32'hFFFE_0000;
  localparam logic [23:0] BOM_UTF8    = 24'hEF_BBBF;
  localparam logic [15:0] BOM_UTF16BE = 16'hFEFF;
  localparam logic [15:0] BOM_UTF16LE = 16'hFFFE;

  localparam logic [1:0] CONT_TAG     = 2'b10;
  localparam logic [2:0] LEAD2_TAG    = 3'b110;
  localparam logic [3:0] LEAD3_TAG    = 4'b1110;
  localparam logic [4:0] LEAD4_TAG    = 5'b11110;

endpackage

// ===== design/ted_accum.sv =====
// Per-byte statistics, UTF-8 validator and end-of-buffer snapshot register.
module ted_accum #(
  parameter int COUNT_BITS = 27
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_fire,
  input  ted_pkg::in_item_t     item,
  input  logic                  snap_take,
  output logic                  snap_ready,
  output logic                  snap_valid,
  output ted_pkg::ted_snap_t    snap,
  output logic [COUNT_BITS-1:0] snap_count,
  output logic [COUNT_BITS-1:0] snap_zero_total,
  output logic [COUNT_BITS-1:0] snap_zero_even,
  output logic [COUNT_BITS-1:0] snap_zero_odd,
  output logic [COUNT_BITS-1:0] snap_zero_low,
  output logic [COUNT_BITS-1:0] snap_zero_high
);
  import ted_pkg::*;

  logic [COUNT_BITS-1:0] pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] zt_r, zt_nxt;
  logic [COUNT_BITS-1:0] ze_r, ze_nxt;
  logic [COUNT_BITS-1:0] zo_r, zo_nxt;
  logic [COUNT_BITS-1:0] zl_r, zl_nxt;
  logic [COUNT_BITS-1:0] zh_r, zh_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic                  high_r, high_nxt;
  logic                  inv_r, inv_nxt;
  logic [1:0]            pend_r, pend_nxt;
  logic [31:0]           head_r, head_nxt;
  logic                  snap_v_r;
  ted_snap_t             snap_r;
  logic [COUNT_BITS-1:0] s_pos_r, s_zt_r, s_ze_r, s_zo_r, s_zl_r, s_zh_r;

  logic [7:0] c;
  logic       is_zero;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign c       = item.data_byte;
  assign is_zero = (c == 8'h00);

  always_comb begin
    pos_nxt   = pos_r;
    zt_nxt    = zt_r;
    ze_nxt    = ze_r;
    zo_nxt    = zo_r;
    zl_nxt    = zl_r;
    zh_nxt    = zh_r;
    phase_nxt = phase_r;
    high_nxt  = high_r;
    inv_nxt   = inv_r;
    pend_nxt  = pend_r;
    head_nxt  = head_r;
    if (!item.buffer_empty) begin
      // Only the first four bytes land in the head window.
      if (pos_r < COUNT_BITS'(4)) begin
        case (pos_r[1:0])
          2'd0:    head_nxt[31:24] = head_r[31:24] | c;
          2'd1:    head_nxt[23:16] = head_r[23:16] | c;
          2'd2:    head_nxt[15:8]  = head_r[15:8] | c;
          default: head_nxt[7:0]   = head_r[7:0] | c;
        endcase
      end
      if (is_zero) begin
        zt_nxt = sat_inc(zt_r);
        if (!phase_r[0]) begin
          ze_nxt = sat_inc(ze_r);
        end else begin
          zo_nxt = sat_inc(zo_r);
        end
        if (!phase_r[1]) begin
          zl_nxt = sat_inc(zl_r);
        end else begin
          zh_nxt = sat_inc(zh_r);
        end
      end
      if (c[7]) begin
        high_nxt = 1'b1;
      end
      if (!inv_r) begin
        if (pend_r != 2'd0) begin
          if (c[7:6] == CONT_TAG) begin
            pend_nxt = pend_r - 2'd1;
          end else begin
            inv_nxt = 1'b1;
          end
        end else if (!c[7]) begin
          pend_nxt = 2'd0;
        end else if (c[7:5] == LEAD2_TAG) begin
          pend_nxt = 2'd1;
        end else if (c[7:4] == LEAD3_TAG) begin
          pend_nxt = 2'd2;
        end else if (c[7:3] == LEAD4_TAG) begin
          pend_nxt = 2'd3;
        end else begin
          inv_nxt = 1'b1;
        end
      end
      pos_nxt   = sat_inc(pos_r);
      phase_nxt = phase_r + 2'd1;
    end
  end

  // The snapshot slot frees up whenever the decision stage takes it.
  assign snap_ready = !snap_v_r || snap_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      zt_r     <= '0;
      ze_r     <= '0;
      zo_r     <= '0;
      zl_r     <= '0;
      zh_r     <= '0;
      phase_r  <= '0;
      high_r   <= 1'b0;
      inv_r    <= 1'b0;
      pend_r   <= '0;
      head_r   <= '0;
      snap_v_r <= 1'b0;
    end else begin
      // A new snapshot may land in the same cycle the old one is taken.
      if (item_fire && item.last) begin
        snap_v_r <= 1'b1;
      end else if (snap_take) begin
        snap_v_r <= 1'b0;
      end
      if (item_fire) begin
        if (item.last) begin
          pos_r    <= '0;
          zt_r     <= '0;
          ze_r     <= '0;
          zo_r     <= '0;
          zl_r     <= '0;
          zh_r     <= '0;
          phase_r  <= '0;
          high_r   <= 1'b0;
          inv_r    <= 1'b0;
          pend_r   <= '0;
          head_r   <= '0;
        end else begin
          pos_r   <= pos_nxt;
          zt_r    <= zt_nxt;
          ze_r    <= ze_nxt;
          zo_r    <= zo_nxt;
          zl_r    <= zl_nxt;
          zh_r    <= zh_nxt;
          phase_r <= phase_nxt;
          high_r  <= high_nxt;
          inv_r   <= inv_nxt;
          pend_r  <= pend_nxt;
          head_r  <= head_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.last) begin
      snap_r.head_bytes            <= head_nxt;
      snap_r.high_bit_seen         <= high_nxt;
      snap_r.utf8_invalid          <= inv_nxt;
      snap_r.pending_continuations <= pend_nxt;
      s_pos_r <= pos_nxt;
      s_zt_r  <= zt_nxt;
      s_ze_r  <= ze_nxt;
      s_zo_r  <= zo_nxt;
      s_zl_r  <= zl_nxt;
      s_zh_r  <= zh_nxt;
    end
  end

  assign snap_valid      = snap_v_r;
  assign snap            = snap_r;
  assign snap_count      = s_pos_r;
  assign snap_zero_total = s_zt_r;
  assign snap_zero_even  = s_ze_r;
  assign snap_zero_odd   = s_zo_r;
  assign snap_zero_low   = s_zl_r;
  assign snap_zero_high  = s_zh_r;

endmodule

// ===== design/ted_decide.sv =====
// Encoding decision from the buffer snapshot, held in the result register.
module ted_decide #(
  parameter int COUNT_BITS = 27
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  snap_valid,
  input  ted_pkg::ted_snap_t    snap,
  input  logic [COUNT_BITS-1:0] snap_count,
  input  logic [COUNT_BITS-1:0] snap_zero_total,
  input  logic [COUNT_BITS-1:0] snap_zero_even,
  input  logic [COUNT_BITS-1:0] snap_zero_odd,
  input  logic [COUNT_BITS-1:0] snap_zero_low,
  input  logic [COUNT_BITS-1:0] snap_zero_high,
  output logic                  snap_take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ted_pkg::out_item_t    out_data
);
  import ted_pkg::*;

  logic      out_v_r;
  out_item_t out_r, res_nxt;
  logic      out_free;
  logic      has4, has3, has2, zero_major;
  logic [31:0] hb;

  assign hb   = snap.head_bytes;
  assign has4 = (snap_count >= COUNT_BITS'(4));
  assign has3 = (snap_count >= COUNT_BITS'(3));
  assign has2 = (snap_count >= COUNT_BITS'(2));
  // More than half of the bytes are zero.
  assign zero_major = ({snap_zero_total, 1'b0} > {1'b0, snap_count});

  always_comb begin
    res_nxt.encoding    = ENC_UTF8;
    res_nxt.mark_length = MARK_NONE;
    if (snap_count == '0) begin
      res_nxt.encoding = ENC_UTF8;
    end else if (has4 && hb == BOM_UTF32BE) begin
      res_nxt.encoding    = ENC_UTF32BE;
      res_nxt.mark_length = MARK_UTF32;
    end else if (has4 && hb == BOM_UTF32LE) begin
      res_nxt.encoding    = ENC_UTF32LE;
      res_nxt.mark_length = MARK_UTF32;
    end else if (has3 && hb[31:8] == BOM_UTF8) begin
      res_nxt.encoding    = ENC_UTF8;
      res_nxt.mark_length = MARK_UTF8;
    end else if (has2 && hb[31:16] == BOM_UTF16BE) begin
      res_nxt.encoding    = ENC_UTF16BE;
      res_nxt.mark_length = MARK_UTF16;
    end else if (has2 && hb[31:16] == BOM_UTF16LE) begin
      res_nxt.encoding    = ENC_UTF16LE;
      res_nxt.mark_length = MARK_UTF16;
    end else if (snap_zero_total != '0) begin
      if (zero_major) begin
        res_nxt.encoding = (snap_zero_low > snap_zero_high) ? ENC_UTF32BE : ENC_UTF32LE;
      end else begin
        res_nxt.encoding = (snap_zero_even > snap_zero_odd) ? ENC_UTF16BE : ENC_UTF16LE;
      end
    end else if (!snap.utf8_invalid && snap.pending_continuations == 2'd0) begin
      res_nxt.encoding = ENC_UTF8;
    end else begin
      res_nxt.encoding = snap.high_bit_seen ? ENC_LATIN1 : ENC_UTF8;
    end
  end

  assign out_free  = !out_v_r || !out_stall;
  assign snap_take = snap_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== design/text_encoding_detector.sv =====
// A result beat passes through the input register, the snapshot register and the result register.
// Throughput: one byte per cycle, from the counter and validator update, unless stalled.
// Bytes that are not last keep flowing while a result waits on a stalled output.
// Reset (synchronous, rst_n low) clears all counters, flags, the head window and valids.
// After each result the statistics restart from zero for the next buffer.
module text_encoding_detector #(
  parameter int COUNT_BITS = 27
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ted_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ted_pkg::out_item_t out_data
);
  import ted_pkg::*;

  logic     in_v_r;
  in_item_t in_item_r;
  logic     in_take, drain;

  logic                  snap_ready, snap_valid, snap_take;
  ted_snap_t             snap;
  logic [COUNT_BITS-1:0] s_count, s_zt, s_ze, s_zo, s_zl, s_zh;

  // A last beat waits in the input register until the snapshot slot is free.
  assign drain    = in_v_r && (!in_item_r.last || snap_ready);
  assign in_stall = in_v_r && !drain;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (drain) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  ted_accum #(
    .COUNT_BITS(COUNT_BITS)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_fire      (drain),
    .item           (in_item_r),
    .snap_take      (snap_take),
    .snap_ready     (snap_ready),
    .snap_valid     (snap_valid),
    .snap           (snap),
    .snap_count     (s_count),
    .snap_zero_total(s_zt),
    .snap_zero_even (s_ze),
    .snap_zero_odd  (s_zo),
    .snap_zero_low  (s_zl),
    .snap_zero_high (s_zh)
  );

  ted_decide #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decide (
    .clk            (clk),
    .rst_n          (rst_n),
    .snap_valid     (snap_valid),
    .snap           (snap),
    .snap_count     (s_count),
    .snap_zero_total(s_zt),
    .snap_zero_even (s_ze),
    .snap_zero_odd  (s_zo),
    .snap_zero_low  (s_zl),
    .snap_zero_high (s_zh),
    .snap_take      (snap_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

// ===== verif/text_encoding_detector_check.sv =====
// Checker for the text encoding detector: predicts each buffer's verdict and compares result beats.
module text_encoding_detector_check #(
  parameter int CNT_W = 27
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ted_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ted_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 waiting_count
);
  import ted_pkg::*;

  typedef logic [CNT_W-1:0] count_t;

  // Running statistics of the buffer now being streamed in.
  count_t      byte_count;
  count_t      zeros_all;
  count_t      zeros_even;
  count_t      zeros_odd;
  count_t      zeros_lo;
  count_t      zeros_hi;
  logic [1:0]  phase;
  logic        saw_high;
  logic        bad_utf8;
  logic [1:0]  owed;
  logic [31:0] head;

  out_item_t verdict_q[$];
  out_item_t oldest;

  function automatic count_t bump(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic clear_stats();
    byte_count = '0;
    zeros_all  = '0;
    zeros_even = '0;
    zeros_odd  = '0;
    zeros_lo   = '0;
    zeros_hi   = '0;
    phase      = '0;
    saw_high   = 1'b0;
    bad_utf8   = 1'b0;
    owed       = '0;
    head       = '0;
  endtask

  task automatic absorb_byte(logic [7:0] c);
    if (byte_count < 4) head[(3 - byte_count[1:0]) * 8 +: 8] = c;
    if (c == 8'h00) begin
      zeros_all = bump(zeros_all);
      if (!phase[0]) zeros_even = bump(zeros_even);
      else zeros_odd = bump(zeros_odd);
      if (phase < 2) zeros_lo = bump(zeros_lo);
      else zeros_hi = bump(zeros_hi);
    end
    if (c[7]) saw_high = 1'b1;
    // Once the stream is known to be broken UTF-8 the validator stops tracking.
    if (!bad_utf8) begin
      if (owed != 0) begin
        if (c[7:6] == CONT_TAG) owed = owed - 1'b1;
        else bad_utf8 = 1'b1;
      end else if (c[7]) begin
        if (c[7:5] == LEAD2_TAG) owed = 2'd1;
        else if (c[7:4] == LEAD3_TAG) owed = 2'd2;
        else if (c[7:3] == LEAD4_TAG) owed = 2'd3;
        else bad_utf8 = 1'b1;
      end
    end
    byte_count = bump(byte_count);
    phase = phase + 1'b1;
  endtask

  function automatic out_item_t judge_buffer();
    out_item_t  r;
    logic [CNT_W:0] twice;
    r.encoding = ENC_UTF8;
    r.mark_length = MARK_NONE;
    twice = {zeros_all, 1'b0};
    if (byte_count == 0) return r;
    if (byte_count >= 4 && head == BOM_UTF32BE) begin
      r.encoding = ENC_UTF32BE;
      r.mark_length = MARK_UTF32;
    end else if (byte_count >= 4 && head == BOM_UTF32LE) begin
      r.encoding = ENC_UTF32LE;
      r.mark_length = MARK_UTF32;
    end else if (byte_count >= 3 && head[31:8] == BOM_UTF8) begin
      r.encoding = ENC_UTF8;
      r.mark_length = MARK_UTF8;
    end else if (byte_count >= 2 && head[31:16] == BOM_UTF16BE) begin
      r.encoding = ENC_UTF16BE;
      r.mark_length = MARK_UTF16;
    end else if (byte_count >= 2 && head[31:16] == BOM_UTF16LE) begin
      r.encoding = ENC_UTF16LE;
      r.mark_length = MARK_UTF16;
    end else if (zeros_all != 0) begin
      if (twice > {1'b0, byte_count})
        r.encoding = (zeros_lo > zeros_hi) ? ENC_UTF32BE : ENC_UTF32LE;
      else
        r.encoding = (zeros_even > zeros_odd) ? ENC_UTF16BE : ENC_UTF16LE;
    end else if (!bad_utf8 && owed == 0) begin
      r.encoding = ENC_UTF8;
    end else begin
      r.encoding = saw_high ? ENC_LATIN1 : ENC_UTF8;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stats();
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_data.encoding, -1);
        end else begin
          oldest = verdict_q.pop_front();
          if (out_data.encoding !== oldest.encoding)
            report_mismatch("encoding", out_data.encoding, oldest.encoding);
          if (out_data.mark_length !== oldest.mark_length)
            report_mismatch("mark_length", out_data.mark_length, oldest.mark_length);
        end
      end
      if (in_valid && !in_stall) begin
        if (!in_data.buffer_empty) absorb_byte(in_data.data_byte);
        if (in_data.last) begin
          verdict_q.push_back(judge_buffer());
          clear_stats();
        end
      end
    end
    waiting_count = verdict_q.size();
  end

endmodule

// ===== verif/text_encoding_detector_test.sv =====
// Testbench top for the text encoding detector: stimulus, flow control and the verdict.
module text_encoding_detector_test;
  import ted_pkg::*;

  // A narrow counter width lets long buffers reach counter saturation.
  localparam int CNT_W = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        waiting_count;

  logic [7:0] bytes_q[$];
  in_item_t   stream_q[$];
  int         rx_cycle = 0;

  text_encoding_detector #(.COUNT_BITS(CNT_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  text_encoding_detector_check #(.CNT_W(CNT_W)) verdict_watch (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .fail_count(fail_count),
    .waiting_count(waiting_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(logic [7:0] b, logic is_last, logic is_empty);
    in_item_t it;
    it.data_byte = b;
    it.last = is_last;
    it.buffer_empty = is_empty;
    stream_q.push_back(it);
  endtask

  // Turns the collected bytes into beats; noisy buffers get stray empty beats mixed in.
  task automatic commit_buffer(bit noisy);
    int i;
    bit tail_empty;
    tail_empty = noisy && bytes_q.size() != 0 && $urandom_range(0, 9) == 0;
    if (bytes_q.size() == 0) push_item(rand_byte(), 1'b1, 1'b1);
    for (i = 0; i < bytes_q.size(); i++) begin
      if (noisy && $urandom_range(0, 99) < 3) push_item(rand_byte(), 1'b0, 1'b1);
      push_item(bytes_q[i], (i == bytes_q.size() - 1) && !tail_empty, 1'b0);
    end
    if (tail_empty) push_item(rand_byte(), 1'b1, 1'b1);
    bytes_q.delete();
  endtask

  task automatic put_utf8(int n);
    logic [7:0] r;
    int k;
    r = rand_byte();
    case (n)
      1: bytes_q.push_back({1'b0, r[6:0]});
      2: bytes_q.push_back({LEAD2_TAG, r[4:0]});
      3: bytes_q.push_back({LEAD3_TAG, r[3:0]});
      default: bytes_q.push_back({LEAD4_TAG, r[2:0]});
    endcase
    for (k = 1; k < n; k++) begin
      r = rand_byte();
      bytes_q.push_back({CONT_TAG, r[5:0]});
    end
  endtask

  task automatic make_random_buffer();
    int kind;
    int len;
    int k;
    bit be;
    logic [7:0] ch;
    kind = $urandom_range(0, 9);
    len = $urandom_range(1, 16);
    be = $urandom_range(0, 1);
    if ($urandom_range(0, 49) == 0) return;
    case (kind)
      0: for (k = 0; k < len; k++) bytes_q.push_back(8'($urandom_range(1, 127)));
      1: for (k = 0; k < len; k++) put_utf8($urandom_range(1, 4));
      2: begin
        if ($urandom_range(0, 2) == 0) begin
          bytes_q.push_back(be ? 8'hFE : 8'hFF);
          bytes_q.push_back(be ? 8'hFF : 8'hFE);
        end
        for (k = 0; k < len; k++) begin
          ch = 8'($urandom_range(1, 255));
          if (be) bytes_q.push_back(($urandom_range(0, 4) == 0) ? rand_byte() : 8'h00);
          bytes_q.push_back(ch);
          if (!be) bytes_q.push_back(($urandom_range(0, 4) == 0) ? rand_byte() : 8'h00);
        end
      end
      3: begin
        if ($urandom_range(0, 2) == 0) begin
          if (be) bytes_q = {bytes_q, 8'h00, 8'h00, 8'hFE, 8'hFF};
          else bytes_q = {bytes_q, 8'hFF, 8'hFE, 8'h00, 8'h00};
        end
        for (k = 0; k < len / 2 + 1; k++) begin
          ch = 8'($urandom_range(1, 255));
          if (be) bytes_q = {bytes_q, 8'h00, 8'h00, 8'h00, ch};
          else bytes_q = {bytes_q, ch, 8'h00, 8'h00, 8'h00};
        end
      end
      4: for (k = 0; k < len; k++)
        bytes_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(128, 255)) :
                                                         8'($urandom_range(1, 127)));
      5: for (k = 0; k < len; k++) bytes_q.push_back(rand_byte());
      6: begin
        // Valid text, then a short or broken multi-byte sequence, at times followed by one ASCII byte.
        for (k = 0; k < len / 2; k++) put_utf8($urandom_range(1, 4));
        put_utf8($urandom_range(2, 4));
        if ($urandom_range(0, 1) == 0) void'(bytes_q.pop_back());
        else bytes_q[bytes_q.size() - 1] = 8'($urandom_range(0, 127));
        if ($urandom_range(0, 1) == 0) put_utf8(1);
      end
      7: begin
        case ($urandom_range(0, 4))
          0: bytes_q = {8'h00, 8'h00, 8'hFE, 8'hFF};
          1: bytes_q = {8'hFF, 8'hFE, 8'h00, 8'h00};
          2: bytes_q = {8'hEF, 8'hBB, 8'hBF};
          3: bytes_q = {8'hFE, 8'hFF};
          default: bytes_q = {8'hFF, 8'hFE};
        endcase
        len = $urandom_range(0, 8);
        for (k = 0; k < len; k++) bytes_q.push_back(rand_byte());
      end
      8: for (k = 0; k < len; k++)
        bytes_q.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : rand_byte());
      default: begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          case ($urandom_range(0, 6))
            0: bytes_q.push_back(8'h00);
            1: bytes_q.push_back(8'hFE);
            2: bytes_q.push_back(8'hFF);
            3: bytes_q.push_back(8'hEF);
            4: bytes_q.push_back(8'hBB);
            5: bytes_q.push_back(8'hBF);
            default: bytes_q.push_back(rand_byte());
          endcase
      end
    endcase
  endtask

  task automatic build_stream();
    int k;
    bit long_zero_done;
    bit long_text_done;
    long_zero_done = 1'b0;
    long_text_done = 1'b0;

    // Directed: empty buffer, every mark, a short mark, single high byte, truncation.
    push_item(8'hFF, 1'b1, 1'b1);
    bytes_q = {8'h00, 8'h00, 8'hFE, 8'hFF};
    commit_buffer(1'b0);
    bytes_q = {8'hFF, 8'hFE, 8'h00, 8'h00};
    commit_buffer(1'b0);
    bytes_q = {8'hEF, 8'hBB, 8'hBF};
    commit_buffer(1'b0);
    bytes_q = {8'hFE, 8'hFF};
    commit_buffer(1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'hFE, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    bytes_q = {8'h00, 8'h00, 8'hFE};
    commit_buffer(1'b0);
    bytes_q = {8'hFF};
    commit_buffer(1'b0);
    push_item(8'h7F, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    push_item(8'hC3, 1'b1, 1'b0);

    while (stream_q.size() < 1650) begin
      if (!long_zero_done && stream_q.size() > 300) begin
        // Mostly zeros and longer than the counters can count.
        for (k = 0; k < 300; k++)
          bytes_q.push_back(($urandom_range(0, 9) != 0) ? 8'h00 : rand_byte());
        long_zero_done = 1'b1;
      end else if (!long_text_done && stream_q.size() > 900) begin
        while (bytes_q.size() < 270) put_utf8($urandom_range(1, 4));
        long_text_done = 1'b1;
      end else begin
        make_random_buffer();
      end
      commit_buffer(1'b1);
    end
  endtask

  task automatic offer_stream();
    int idx;
    bit quiet;
    for (idx = 0; idx < stream_q.size(); idx++) begin
      @(negedge clk);
      quiet = idx >= 300 && idx < 650;
      while (!quiet && $urandom_range(0, 99) < 6) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data <= stream_q[idx];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off so the block backs up, then a quiet stretch.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle >= 800 && rx_cycle < 1100) out_stall <= 1'b1;
    else if (rx_cycle >= 1300 && rx_cycle < 1700) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 6);
  end

  initial begin
    build_stream();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    offer_stream();
    while (waiting_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && waiting_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
